### hw/rtl/bplpg_pkg.sv
// Shared types and constants of the bipolar LED PWM pattern generator.
package bplpg_pkg;

  localparam int LEVEL_W      = 12;
  localparam int CHAN_W       = 4;
  localparam int SLOT_W       = 8;
  localparam int PWM_W        = 32;
  localparam int DUTY_SHIFT   = 3;
  localparam int DUTY_W       = LEVEL_W - DUTY_SHIFT + 1;
  localparam int ROW_CHANNELS = 8;
  localparam int MAX_CHANNELS = 16;

  // Bit offsets of the four color groups inside the PWM word.
  localparam int GREEN_TOP_OFS = 0;
  localparam int RED_TOP_OFS   = 8;
  localparam int GREEN_BOT_OFS = 16;
  localparam int RED_BOT_OFS   = 24;

  localparam int CHANNELS_DEF = 16;
  localparam int SLOTS_DEF    = 256;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_SLOT = 1'b1
  } action_t;

  typedef struct packed {
    action_t                    action;
    logic [CHAN_W-1:0]          channel;
    logic signed [LEVEL_W-1:0]  level;
    logic                       frame_end;
  } in_t;

  typedef struct packed {
    logic [PWM_W-1:0]  pwm_word;
    logic [SLOT_W-1:0] slot_index;
    logic              period_end;
  } out_t;

endpackage

### hw/rtl/bipolar_led_pwm_pattern_generator.sv
// Top level of the bipolar LED PWM pattern generator.
//
// The block drives up to 16 bipolar (green/red) LED channels with bit-plane PWM.
// A load word (action ACT_LOAD) writes one signed 12-bit level into the shadow
// set; when it carries frame_end, the shadow set, including this write, is copied
// into the active set in the same step, so a new frame shows up atomically. A
// slot word (action ACT_SLOT) produces one 32-bit LED word for the current slot
// of a SLOTS-long period and then advances the slot counter, which wraps after
// SLOTS-1; period_end marks the last slot. The duty of a channel is |level| >> 3:
// a level of zero or above lights green while the slot is below the duty, a
// negative level lights red the same way, and -2048 keeps red on in every slot.
// Channels 0-7 have green on bits 0-7 and red on bits 8-15; channels 8-15 have
// green on bits 16-23 and red on bits 24-31. A load to a channel at or above
// CHANNELS is dropped, although its frame_end still commits. Throughput is one
// word per clock while no slot word waits: an accepted word is held in an input
// register, and the parallel duty compares, one per channel, run from there into
// the output register, which holds the result of each slot word. Load words
// produce no result and never wait on the output side; a slot word waits only
// while the output register is full and out_ready is low.
module bipolar_led_pwm_pattern_generator
  import bplpg_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF,
  parameter int SLOTS    = SLOTS_DEF
) (
  input  logic clk,
  input  logic rst_n,

  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,

  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  // Input register stage.
  logic s1_valid_r, s1_valid_nxt;
  in_t  s1_item_r;

  // Level storage: the shadow set collects loads, the active set drives the LEDs.
  logic [LEVEL_W-1:0] shadow_r [CHANNELS];
  logic [LEVEL_W-1:0] active_r [CHANNELS];
  logic [LEVEL_W-1:0] shadow_nxt [CHANNELS];
  logic [LEVEL_W-1:0] active_nxt [CHANNELS];

  logic [SLOT_W-1:0] slot_r, slot_nxt;

  // Output register stage.
  logic out_valid_r, out_valid_nxt;
  out_t out_data_r, out_data_nxt;

  logic out_free;
  logic s1_advance;
  logic s1_is_load;
  logic slot_last;
  logic [PWM_W-1:0] pwm_word;

  // The output register can take a new result when empty or being drained.
  assign out_free   = !out_valid_r || out_ready;
  assign s1_is_load = (s1_item_r.action == ACT_LOAD);
  // Loads retire at once; slot words need room in the output register.
  assign s1_advance = s1_valid_r && (s1_is_load || out_free);
  assign in_ready   = !s1_valid_r || s1_advance;

  assign slot_last = (slot_r == SLOT_W'(SLOTS - 1));

  // One compare per channel against the current slot, all in parallel.
  always_comb begin
    logic               neg;
    logic [LEVEL_W-1:0] mag;
    logic [DUTY_W-1:0]  duty;
    pwm_word = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      neg  = active_r[c][LEVEL_W-1];
      mag  = neg ? (~active_r[c] + LEVEL_W'(1)) : active_r[c];
      duty = DUTY_W'({1'b0, mag} >> DUTY_SHIFT);
      if ({{(DUTY_W-SLOT_W){1'b0}}, slot_r} < duty) begin
        if (c < ROW_CHANNELS) begin
          if (neg) begin
            pwm_word[RED_TOP_OFS + (c % ROW_CHANNELS)] = 1'b1;
          end else begin
            pwm_word[GREEN_TOP_OFS + (c % ROW_CHANNELS)] = 1'b1;
          end
        end else begin
          if (neg) begin
            pwm_word[RED_BOT_OFS + (c % ROW_CHANNELS)] = 1'b1;
          end else begin
            pwm_word[GREEN_BOT_OFS + (c % ROW_CHANNELS)] = 1'b1;
          end
        end
      end
    end
  end

  // Next-state logic for storage, slot counter and both register stages.
  always_comb begin
    s1_valid_nxt  = s1_advance ? 1'b0 : s1_valid_r;
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
    end

    shadow_nxt    = shadow_r;
    active_nxt    = active_r;
    slot_nxt      = slot_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    out_data_nxt  = out_data_r;

    if (s1_advance) begin
      if (s1_is_load) begin
        for (int c = 0; c < CHANNELS; c++) begin
          if ({1'b0, s1_item_r.channel} == (CHAN_W + 1)'(c)) begin
            shadow_nxt[c] = s1_item_r.level;
          end
        end
        if (s1_item_r.frame_end) begin
          active_nxt = shadow_nxt;
        end
      end else begin
        out_valid_nxt           = 1'b1;
        out_data_nxt.pwm_word   = pwm_word;
        out_data_nxt.slot_index = slot_r;
        out_data_nxt.period_end = slot_last;
        slot_nxt = slot_last ? '0 : slot_r + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      slot_r      <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        shadow_r[c] <= '0;
        active_r[c] <= '0;
      end
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      slot_r      <= slot_nxt;
      shadow_r    <= shadow_nxt;
      active_r    <= active_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_data;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### verif/tb_top.sv
// Self-checking testbench for the bipolar LED PWM pattern generator.
`timescale 1ns / 1ps

module tb_top
  import bplpg_pkg::*;
();

  // A slot word passes the input and the output register before it shows up, so
  // this settling time is enough once the last expected word has come out.
  localparam int SETTLE_CYCLES  = 8;
  // The run is stopped when no word moves on either channel for this long.
  // Even with the heavily stalled receiver of phase one, gaps stay far below it.
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int MAX_REPORTS    = 10;

  logic clk = 1'b0;
  logic rst_n;

  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  // Percent of cycles in which the sender holds back a word and the receiver
  // refuses one. The main sequence changes them between traffic phases.
  int in_idle_pct;
  int out_idle_pct;

  int mismatches  = 0;
  int idle_cycles = 0;

  // Private copy of the block's state: the level sets and the slot counter.
  logic signed [LEVEL_W-1:0] shadow_lvl [MAX_CHANNELS];
  logic signed [LEVEL_W-1:0] active_lvl [MAX_CHANNELS];
  logic [SLOT_W-1:0]         slot_ctr;

  // Slot words predicted but not yet seen at the output, oldest first.
  out_t pending_slot_words[$];

  always #5 clk = ~clk;

  bipolar_led_pwm_pattern_generator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Builds the LED word for the current slot from the active levels. A channel
  // lights while the slot is below |level| >> 3; the sign picks red or green,
  // and the row picks the low or the high half of the word.
  function automatic out_t predict_slot_word();
    out_t w;
    int   lvl;
    int   duty;
    int   ofs;
    w.pwm_word = '0;
    for (int c = 0; c < CHANNELS_DEF; c++) begin
      lvl  = int'(active_lvl[c]);
      duty = (lvl < 0 ? -lvl : lvl) >> DUTY_SHIFT;
      if (slot_ctr < duty) begin
        if (c < ROW_CHANNELS) begin
          ofs = (lvl < 0) ? RED_TOP_OFS : GREEN_TOP_OFS;
        end else begin
          ofs = (lvl < 0) ? RED_BOT_OFS : GREEN_BOT_OFS;
        end
        w.pwm_word[ofs + c % ROW_CHANNELS] = 1'b1;
      end
    end
    w.slot_index = slot_ctr;
    w.period_end = (slot_ctr == SLOTS_DEF - 1);
    return w;
  endfunction

  // Applies one accepted word to the private state. A load writes the shadow
  // set and, with frame_end, commits the whole set including this write. A slot
  // word queues its expected LED word and steps the counter, which wraps.
  task automatic track_accepted_word(input in_t w);
    if (w.action == ACT_LOAD) begin
      shadow_lvl[w.channel] = w.level;
      if (w.frame_end) begin
        active_lvl = shadow_lvl;
      end
    end else begin
      pending_slot_words.push_back(predict_slot_word());
      slot_ctr = (slot_ctr == SLOTS_DEF - 1) ? '0 : slot_ctr + 1'b1;
    end
  endtask

  // Presents one word and returns at the edge where it is taken. Valid is left
  // high afterwards, so back-to-back words keep it up without a dip; a random
  // hold-off lowers it first, always in a time step of its own.
  task automatic send_word(input in_t w);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    track_accepted_word(w);
  endtask

  task automatic send_load(input logic [CHAN_W-1:0] ch, input logic signed [LEVEL_W-1:0] lvl,
                           input logic fend);
    in_t w;
    w.action    = ACT_LOAD;
    w.channel   = ch;
    w.level     = lvl;
    w.frame_end = fend;
    send_word(w);
  endtask

  // Channel, level and frame_end mean nothing on a slot word, so they carry
  // random bits to show that the block ignores them.
  task automatic send_slot();
    in_t w;
    w.action    = ACT_SLOT;
    w.channel   = CHAN_W'($urandom);
    w.level     = LEVEL_W'($urandom);
    w.frame_end = 1'($urandom);
    send_word(w);
  endtask

  // Stops sending and waits until every predicted slot word has come out,
  // plus a settling time for anything still in flight.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (pending_slot_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Levels lean on the interesting values: both full-scale ends, zero and the
  // region around zero where the duty stays between zero and two.
  function automatic logic signed [LEVEL_W-1:0] pick_level();
    int v;
    case ($urandom_range(7))
      0: return {1'b1, {(LEVEL_W-1){1'b0}}};
      1: return {1'b0, {(LEVEL_W-1){1'b1}}};
      2: return '0;
      3: begin
        v = int'($urandom_range(32)) - 16;
        return v[LEVEL_W-1:0];
      end
      default: return LEVEL_W'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input out_t expd, input out_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t ns: %s: expected word %h slot %0d end %b, got word %h slot %0d end %b",
               $time, what, expd.pwm_word, expd.slot_index, expd.period_end,
               got.pwm_word, got.slot_index, got.period_end);
    end
  endtask

  // Receiver: drives a fresh random ready at every edge and checks each word
  // taken at that edge against the oldest prediction, field by field.
  always @(posedge clk) begin
    out_t expd;
    out_ready <= ($urandom_range(99) >= out_idle_pct);
    if (rst_n && out_valid && out_ready) begin
      if (pending_slot_words.size() == 0) begin
        expd = '0;
        report_mismatch("unexpected slot word", expd, out_data);
      end else begin
        expd = pending_slot_words.pop_front();
        if (out_data.pwm_word !== expd.pwm_word || out_data.slot_index !== expd.slot_index ||
            out_data.period_end !== expd.period_end) begin
          report_mismatch("slot word mismatch", expd, out_data);
        end
      end
    end
  end

  // Watchdog: any word moving on either channel restarts the count.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Right after reset every level is zero, so the first slots are dark and the
  // counter starts at slot zero.
  task automatic test_reset_state();
    repeat (3) send_slot();
  endtask

  // Full negative stays red in every slot, full positive is green in all but
  // the last slot, zero stays dark, and small levels sit on the duty boundary.
  // Both rows and both ends of the channel range are touched.
  task automatic test_full_scale_levels();
    send_load(4'd0, -12'sd2048, 1'b0);
    send_load(4'd1, 12'sd2047, 1'b0);
    send_load(4'd2, 12'sd0, 1'b0);
    send_load(4'd3, -12'sd1, 1'b0);
    send_load(4'd4, 12'sd7, 1'b0);
    send_load(4'd5, 12'sd8, 1'b0);
    send_load(4'd8, -12'sd9, 1'b0);
    send_load(4'd15, 12'sd2047, 1'b1);
    repeat (3) send_slot();
  endtask

  // A load without frame_end must not reach the LEDs until a later load
  // commits; the commit carries its own write along with the earlier one.
  // The sender then holds off until every word has come back.
  task automatic test_shadow_commit();
    send_load(4'd6, -12'sd2048, 1'b0);
    send_slot();
    send_load(4'd12, 12'sd1000, 1'b1);
    send_slot();
    wait_for_drain();
  endtask

  // Mostly well-formed frame updates (a run of loads closed by frame_end)
  // followed by bursts of slot words, with some stray loads and some frames
  // left uncommitted mixed in. Slot words dominate, so the counter wraps.
  task automatic test_random_traffic(input int n_words);
    int sent;
    int n_loads;
    int n_slots;
    logic close_frame;
    sent = 0;
    while (sent < n_words) begin
      if ($urandom_range(99) < 65) begin
        n_loads     = $urandom_range(1, MAX_CHANNELS);
        close_frame = ($urandom_range(9) != 0);
        for (int i = 0; i < n_loads; i++) begin
          send_load(CHAN_W'($urandom), pick_level(), close_frame && (i == n_loads - 1));
        end
        sent += n_loads;
      end else begin
        send_load(CHAN_W'($urandom), pick_level(), 1'($urandom));
        sent++;
      end
      n_slots = $urandom_range(1, 40);
      repeat (n_slots) send_slot();
      sent += n_slots;
    end
  endtask

  initial begin
    in_valid     <= 1'b0;
    in_data      <= '0;
    out_ready    <= 1'b0;
    rst_n        <= 1'b0;
    in_idle_pct  = 12;
    out_idle_pct = 76;
    foreach (shadow_lvl[i]) begin
      shadow_lvl[i] = '0;
      active_lvl[i] = '0;
    end
    slot_ctr = '0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Phase one: busy sender, heavily stalled receiver.
    test_reset_state();
    test_full_scale_levels();
    test_shadow_commit();
    test_random_traffic(270);
    wait_for_drain();

    // Phase two: the roles swap.
    in_idle_pct  = 76;
    out_idle_pct = 12;
    test_random_traffic(270);
    wait_for_drain();

    // Phase three: full rate on both sides.
    in_idle_pct  = 0;
    out_idle_pct = 0;
    test_random_traffic(270);
    wait_for_drain();

    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
